// ===== rtl/jst_pkg.sv =====
package jst_pkg;

    localparam int PID_W   = 31;
    localparam int JID_W   = 16;
    localparam int STATE_W = 2;
    localparam int OP_W    = 3;

    localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND_PID = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND_JID = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND_FG  = 3'd4;
    localparam logic [OP_W-1:0] OP_SET_PID  = 3'd5;
    localparam logic [OP_W-1:0] OP_SET_JID  = 3'd6;

    localparam logic [STATE_W-1:0] JOB_UNDEF = 2'd0;
    localparam logic [STATE_W-1:0] JOB_FG    = 2'd1;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [PID_W-1:0]   proc_id;
        logic [JID_W-1:0]   job_id;
        logic [STATE_W-1:0] new_state;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [PID_W-1:0]   hit_proc_id;
        logic [JID_W-1:0]   hit_job_id;
        logic [STATE_W-1:0] hit_state;
    } t_out_item;

    // Classified command as held in the queue
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               refuse;
        logic [PID_W-1:0]   proc_id;
        logic [JID_W-1:0]   job_id;
        logic [STATE_W-1:0] new_state;
    } t_job_cmd;

endpackage

// ===== rtl/jst_in_if.sv =====
interface jst_in_if import jst_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/jst_out_if.sv =====
interface jst_out_if import jst_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/job_slot_table.sv =====
// Job slot table: SLOTS entries of (process id, job id, run state).
//
// Channels: i_cmd carries one command beat (op, proc_id, job_id,
// new_state); o_rsp carries one response beat per command (found,
// hit_proc_id, hit_job_id, hit_state). Both use valid/ready; a beat
// moves on a clock edge where both are high.
//
// The back stage registers a response at the edge that accepts its command,
// so the response beat is offered from the cycle after.
// The back stage takes one command per cycle while its response register is
// free; a remove that hits then holds it in S_MAX while the max tree over
// the remaining job ids sets the next job id.
//
// Reset (i_rst_n low, synchronous): all slots go free, next job id is 1,
// the queue empties and o_rsp.valid drops.
//
// When the receiver stalls, the response register holds its beat, the back
// stage stops taking commands, and the two-entry front queue fills; i_cmd
// then drops ready until the receiver takes a beat.
module job_slot_table import jst_pkg::*; #(
    parameter int SLOTS   = 16,
    parameter int ID_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jst_in_if.sink    i_cmd,
    jst_out_if.source o_rsp
);

    logic     q_valid;
    logic     q_ready;
    t_job_cmd q_cmd;

    // Front: accept, classify and queue commands
    jst_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_ready (q_ready)
    );

    // Back: match against the table, update it, register the response
    jst_back #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_ready (q_ready),
        .o_rsp     (o_rsp)
    );

endmodule

// ===== rtl/jst_front.sv =====
module jst_front import jst_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    jst_in_if.sink   i_cmd,
    output logic     o_q_valid,
    output t_job_cmd o_q_cmd,
    input  logic     i_q_ready
);

    t_job_cmd         r_q [0:Q_DEPTH-1];
    logic [Q_AW-1:0]  r_wptr;
    logic [Q_AW-1:0]  r_rptr;
    logic [Q_AW:0]    r_count;
    t_job_cmd         n_cmd;
    logic             push;
    logic             pop;

    // Refuse a zero key and the unused op code up front
    always_comb begin
        n_cmd.op        = i_cmd.data.op;
        n_cmd.proc_id   = i_cmd.data.proc_id;
        n_cmd.job_id    = i_cmd.data.job_id;
        n_cmd.new_state = i_cmd.data.new_state;
        case (i_cmd.data.op)
            OP_ADD, OP_REMOVE, OP_FIND_PID, OP_SET_PID: begin
                n_cmd.refuse = (i_cmd.data.proc_id == '0);
            end
            OP_FIND_JID, OP_SET_JID: begin
                n_cmd.refuse = (i_cmd.data.job_id == '0);
            end
            OP_FIND_FG: begin
                n_cmd.refuse = 1'b0;
            end
            default: begin
                n_cmd.refuse = 1'b1;
            end
        endcase
    end

    assign i_cmd.ready = (r_count != (Q_AW+1)'(Q_DEPTH));
    assign push        = i_cmd.valid && i_cmd.ready;
    assign o_q_valid   = (r_count != '0);
    assign o_q_cmd     = r_q[r_rptr];
    assign pop         = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/jst_back.sv =====
module jst_back import jst_pkg::*; #(
    parameter int SLOTS   = 16,
    parameter int ID_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job_cmd  i_q_cmd,
    output logic      o_q_ready,
    jst_out_if.source o_rsp
);

    localparam int IW  = $clog2(SLOTS);
    localparam int CW  = (ID_BITS > JID_W) ? ID_BITS : JID_W;
    localparam int LVL = $clog2(SLOTS);
    localparam int P   = 1 << LVL;

    localparam logic S_EXEC = 1'b0;
    localparam logic S_MAX  = 1'b1;

    logic [PID_W-1:0]   r_pid [0:SLOTS-1];
    logic [ID_BITS-1:0] r_jid [0:SLOTS-1];
    logic [STATE_W-1:0] r_st  [0:SLOTS-1];
    logic [ID_BITS-1:0] r_next_id;
    logic               r_state;
    logic               r_ovalid;
    t_out_item          r_odata;

    logic [SLOTS-1:0]   free_vec;
    logic [SLOTS-1:0]   pid_vec;
    logic [SLOTS-1:0]   jid_vec;
    logic [SLOTS-1:0]   fg_vec;
    logic [SLOTS-1:0]   sel_vec;
    logic [IW-1:0]      idx;
    logic               hit;
    logic               fire;
    logic               out_free;
    logic [ID_BITS-1:0] n_next_add;
    logic [CW-1:0]      next_ext;
    logic [CW-1:0]      slot_jid_ext;
    t_out_item          n_odata;
    logic [ID_BITS-1:0] tr [1:2*P-1];

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            free_vec[i] = (r_pid[i] == '0);
            pid_vec[i]  = (r_pid[i] == i_q_cmd.proc_id);
            jid_vec[i]  = (CW'(r_jid[i]) == CW'(i_q_cmd.job_id));
            fg_vec[i]   = (r_st[i] == JOB_FG);
        end
    end

    always_comb begin
        case (i_q_cmd.op)
            OP_ADD:                                sel_vec = free_vec;
            OP_REMOVE, OP_FIND_PID, OP_SET_PID:    sel_vec = pid_vec;
            OP_FIND_JID, OP_SET_JID:               sel_vec = jid_vec;
            OP_FIND_FG:                            sel_vec = fg_vec;
            default:                               sel_vec = '0;
        endcase
    end

    // Lowest matching slot wins
    always_comb begin
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (sel_vec[i]) begin
                idx = IW'(i);
            end
        end
    end

    assign hit          = (|sel_vec) && !i_q_cmd.refuse;
    assign next_ext     = CW'(r_next_id);
    assign slot_jid_ext = CW'(r_jid[idx]);

    always_comb begin
        n_next_add = r_next_id + 1'b1;
        if (32'(n_next_add) > 32'(SLOTS)) begin
            n_next_add = ID_BITS'(1);
        end
    end

    always_comb begin
        n_odata = '0;
        if (hit) begin
            n_odata.found       = 1'b1;
            n_odata.hit_proc_id = r_pid[idx];
            n_odata.hit_job_id  = slot_jid_ext[JID_W-1:0];
            n_odata.hit_state   = r_st[idx];
            case (i_q_cmd.op)
                OP_ADD: begin
                    n_odata.hit_proc_id = i_q_cmd.proc_id;
                    n_odata.hit_job_id  = next_ext[JID_W-1:0];
                    n_odata.hit_state   = i_q_cmd.new_state;
                end
                OP_REMOVE: begin
                    n_odata.hit_state = JOB_UNDEF;
                end
                OP_SET_PID, OP_SET_JID: begin
                    n_odata.hit_state = i_q_cmd.new_state;
                end
                default: begin
                    n_odata.hit_state = r_st[idx];
                end
            endcase
        end
    end

    // Max tree over the job ids, used the cycle after a remove
    always_comb begin
        for (int i = 0; i < P; i++) begin
            if (i < SLOTS) begin
                tr[P+i] = r_jid[i % SLOTS];
            end else begin
                tr[P+i] = '0;
            end
        end
        for (int k = P - 1; k >= 1; k--) begin
            tr[k] = (tr[2*k] > tr[2*k+1]) ? tr[2*k] : tr[2*k+1];
        end
    end

    assign out_free    = !r_ovalid || o_rsp.ready;
    assign o_q_ready   = (r_state == S_EXEC) && out_free;
    assign fire        = i_q_valid && o_q_ready;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_odata <= n_odata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_pid[i] <= '0;
                r_jid[i] <= '0;
                r_st[i]  <= JOB_UNDEF;
            end
            r_next_id <= ID_BITS'(1);
            r_state   <= S_EXEC;
            r_ovalid  <= 1'b0;
        end else begin
            if (fire) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_EXEC: begin
                    if (fire && hit) begin
                        case (i_q_cmd.op)
                            OP_ADD: begin
                                r_pid[idx] <= i_q_cmd.proc_id;
                                r_jid[idx] <= r_next_id;
                                r_st[idx]  <= i_q_cmd.new_state;
                                r_next_id  <= n_next_add;
                            end
                            OP_REMOVE: begin
                                r_pid[idx] <= '0;
                                r_jid[idx] <= '0;
                                r_st[idx]  <= JOB_UNDEF;
                                r_state    <= S_MAX;
                            end
                            OP_SET_PID, OP_SET_JID: begin
                                r_st[idx] <= i_q_cmd.new_state;
                            end
                            default: begin
                                r_state <= S_EXEC;
                            end
                        endcase
                    end
                end
                S_MAX: begin
                    r_next_id <= tr[1] + 1'b1;
                    r_state   <= S_EXEC;
                end
                default: begin
                    r_state <= S_EXEC;
                end
            endcase
        end
    end

endmodule

// ===== rtl/jst_checker.sv =====
module jst_checker import jst_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_rsp_valid,
    input logic      i_rsp_ready,
    input t_out_item i_rsp_data
);

    // Hold a stalled response beat
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("response beat dropped or changed while stalled");

    // No response right out of reset
    a_rsp_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_rsp_valid)
        else $error("response valid right after reset");

    // A miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_data.found |->
            i_rsp_data.hit_proc_id == '0 && i_rsp_data.hit_job_id == '0 &&
            i_rsp_data.hit_state == '0)
        else $error("miss with nonzero payload");

    // A hit always names an occupied slot
    a_hit_pid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.found |-> i_rsp_data.hit_proc_id != '0)
        else $error("hit on a free slot");

endmodule

bind job_slot_table jst_checker u_jst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

// ===== verif/job_slot_checker.sv =====
`timescale 1ns / 100ps

module job_slot_checker import jst_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    jst_in_if    i_cmd,
    jst_out_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_hits,
    output int   o_full_adds
);

    localparam int REPORT_LIMIT = 10;

    logic [PID_W-1:0]   tbl_pid   [SLOTS];
    logic [JID_W-1:0]   tbl_jid   [SLOTS];
    logic [STATE_W-1:0] tbl_state [SLOTS];
    logic [JID_W-1:0]   next_jid;

    t_out_item expected_rsp_q [$];

    int fail_count = 0;
    int checked    = 0;
    int hits       = 0;
    int full_adds  = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_rsp_q.size();
    assign o_checked    = checked;
    assign o_hits       = hits;
    assign o_full_adds  = full_adds;

    function automatic int slot_of_pid(logic [PID_W-1:0] pid);
        int s;
        for (s = 0; s < SLOTS; s++)
            if (tbl_pid[s] == pid) return s;
        return -1;
    endfunction

    function automatic int slot_of_jid(logic [JID_W-1:0] jid);
        int s;
        for (s = 0; s < SLOTS; s++)
            if (tbl_jid[s] == jid) return s;
        return -1;
    endfunction

    // Apply one command to the shadow table and return the response it owes.
    function automatic t_out_item predict_job_op(t_in_item cmd);
        t_out_item        res;
        int               hit;
        int               k;
        logic [JID_W-1:0] top_jid;
        res = '0;
        hit = -1;
        case (cmd.op)
            OP_ADD: begin
                if (cmd.proc_id != '0) hit = slot_of_pid('0);
                if (hit >= 0) begin
                    tbl_pid[hit]   = cmd.proc_id;
                    tbl_state[hit] = cmd.new_state;
                    tbl_jid[hit]   = next_jid;
                    next_jid       = next_jid + 1'b1;
                    if (next_jid > SLOTS) next_jid = 1;
                end
            end
            OP_REMOVE: begin
                if (cmd.proc_id != '0) k = slot_of_pid(cmd.proc_id);
                else k = -1;
                if (k >= 0) begin
                    // cleared slot reports state undefined
                    res.found       = 1'b1;
                    res.hit_proc_id = tbl_pid[k];
                    res.hit_job_id  = tbl_jid[k];
                    res.hit_state   = JOB_UNDEF;
                    tbl_pid[k]      = '0;
                    tbl_jid[k]      = '0;
                    tbl_state[k]    = JOB_UNDEF;
                    top_jid = '0;
                    for (k = 0; k < SLOTS; k++)
                        if (tbl_jid[k] > top_jid) top_jid = tbl_jid[k];
                    next_jid = top_jid + 1'b1;
                end
            end
            OP_FIND_PID: if (cmd.proc_id != '0) hit = slot_of_pid(cmd.proc_id);
            OP_FIND_JID: if (cmd.job_id != '0) hit = slot_of_jid(cmd.job_id);
            OP_FIND_FG: begin
                for (k = SLOTS - 1; k >= 0; k--)
                    if (tbl_state[k] == JOB_FG) hit = k;
            end
            OP_SET_PID: begin
                if (cmd.proc_id != '0) hit = slot_of_pid(cmd.proc_id);
                if (hit >= 0) tbl_state[hit] = cmd.new_state;
            end
            OP_SET_JID: begin
                if (cmd.job_id != '0) hit = slot_of_jid(cmd.job_id);
                if (hit >= 0) tbl_state[hit] = cmd.new_state;
            end
            default: ;
        endcase
        if (hit >= 0) begin
            res.found       = 1'b1;
            res.hit_proc_id = tbl_pid[hit];
            res.hit_job_id  = tbl_jid[hit];
            res.hit_state   = tbl_state[hit];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        int        k;
        if (!i_rst_n) begin
            for (k = 0; k < SLOTS; k++) begin
                tbl_pid[k]   = '0;
                tbl_jid[k]   = '0;
                tbl_state[k] = JOB_UNDEF;
            end
            next_jid = 1;
            expected_rsp_q.delete();
        end else begin
            // check the response beat first: it always belongs to an older command
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.data;
                if (expected_rsp_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected response found=%0b pid=%h jid=%h st=%0d",
                                 $time, got.found, got.hit_proc_id, got.hit_job_id,
                                 got.hit_state);
                end else begin
                    want = expected_rsp_q.pop_front();
                    checked++;
                    if (got.found !== want.found || got.hit_proc_id !== want.hit_proc_id ||
                        got.hit_job_id !== want.hit_job_id ||
                        got.hit_state !== want.hit_state) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("%0t: response mismatch", $time);
                            $display("  expected found=%0b pid=%h jid=%h st=%0d",
                                     want.found, want.hit_proc_id, want.hit_job_id,
                                     want.hit_state);
                            $display("  actual   found=%0b pid=%h jid=%h st=%0d",
                                     got.found, got.hit_proc_id, got.hit_job_id,
                                     got.hit_state);
                        end
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                want = predict_job_op(i_cmd.data);
                if (want.found) hits++;
                if (i_cmd.data.op == OP_ADD && i_cmd.data.proc_id != '0 && !want.found)
                    full_adds++;
                expected_rsp_q.push_back(want);
            end
        end
    end

endmodule

// ===== verif/job_slot_table_tb.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the job slot table. The checker beside the DUT
// watches both channels, shadows the table and compares every response beat.
module job_slot_table_tb;
    import jst_pkg::*;

    localparam int SLOTS          = 16;
    localparam int ID_BITS        = 16;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int SEGMENT_LEN    = 60;
    localparam int MAX_IDLE       = 16;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POOL_SIZE      = 24;

    // Segment flavors: fill the table, drain it, or mix freely
    localparam int BIAS_FILL  = 0;
    localparam int BIAS_DRAIN = 1;
    localparam int BIAS_MIXED = 2;

    // Opcode the block leaves unused, and run states the package does not name
    localparam logic [OP_W-1:0]    OP_UNUSED   = 3'd7;
    localparam logic [STATE_W-1:0] JOB_BG      = 2'd2;
    localparam logic [STATE_W-1:0] JOB_STOPPED = 2'd3;

    localparam logic [PID_W-1:0] PID_MAX = '1;
    localparam logic [JID_W-1:0] JID_MAX = '1;

    logic i_clk;
    logic i_rst_n;

    jst_in_if  cmd_if ();
    jst_out_if rsp_if ();

    int fail_count;
    int pending;
    int checked;
    int hits;
    int full_adds;

    int sent = 0;
    int directed_sent = 0;
    int holds_asked = 0;
    int holds_done = 0;
    int idle_cycles;
    bit no_gaps = 1'b0;

    logic [PID_W-1:0] pid_pool [POOL_SIZE];

    job_slot_table #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    job_slot_checker #(
        .SLOTS (SLOTS)
    ) u_job_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits),
        .o_full_adds  (full_adds)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_in_item make_cmd(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                                          logic [JID_W-1:0] jid, logic [STATE_W-1:0] st);
        t_in_item c;
        c.op        = op;
        c.proc_id   = pid;
        c.job_id    = jid;
        c.new_state = st;
        return c;
    endfunction

    // Mostly pool pids so removes and lookups hit; the rest sweep every pid bit.
    function automatic logic [PID_W-1:0] pick_pid();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) return '0;
        if (roll < 8) return PID_MAX;
        if (roll < 16) return PID_W'($urandom);
        return pid_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Live job ids stay small; zero, all ones and wide values still show up.
    function automatic logic [JID_W-1:0] pick_jid();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return '0;
        if (roll < 20) return JID_W'($urandom_range(0, 65535));
        if (roll < 24) return JID_MAX;
        return JID_W'($urandom_range(1, SLOTS + 2));
    endfunction

    function automatic t_in_item random_cmd(int bias);
        t_in_item c;
        int       roll;
        int       add_pct;
        int       rem_pct;
        case (bias)
            BIAS_FILL:  begin add_pct = 55; rem_pct = 8;  end
            BIAS_DRAIN: begin add_pct = 10; rem_pct = 50; end
            default:    begin add_pct = 25; rem_pct = 25; end
        endcase
        c.proc_id   = pick_pid();
        c.job_id    = pick_jid();
        c.new_state = STATE_W'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        if (roll < 3)
            c.op = OP_UNUSED;
        else if (roll < 3 + add_pct)
            c.op = OP_ADD;
        else if (roll < 3 + add_pct + rem_pct)
            c.op = OP_REMOVE;
        else
            c.op = OP_W'($urandom_range(int'(OP_FIND_PID), int'(OP_SET_JID)));
        return c;
    endfunction

    // Offer one command beat after a random gap; hold valid until it is taken.
    task automatic send_cmd(input t_in_item cmd);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= cmd;
        do @(posedge i_clk); while (!cmd_if.ready);
        sent++;
    endtask

    // Receiver: stall a random number of cycles before each beat, run whole
    // stretches without stalls, and hold off for a long stretch on request.
    initial begin
        int stall;
        int beats;
        bit steady;
        beats  = 0;
        steady = 1'b0;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (beats % 64 == 0) steady = ($urandom_range(0, 3) == 0);
            if (holds_done < holds_asked) begin
                // hold ready low so the queue fills and input ready drops
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                holds_done++;
            end
            stall = steady ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            beats++;
        end
    end

    // Watchdog: end the run once no beat has moved for too long.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no beat for %0d cycles, %0d responses outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_in_item c;
        int       seg;
        int       k;
        int       counted;
        int       seg_bias;

        cmd_if.valid <= 1'b0;
        cmd_if.data  <= '0;
        i_rst_n      <= 1'b0;

        // pid pool: a few small ids plus wide random ones
        for (k = 0; k < POOL_SIZE; k++)
            pid_pool[k] = (k < 8) ? PID_W'(k + 1) : PID_W'($urandom_range(1, 32'h7fffffff));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table misses, zero pid/job id refusals, unused opcode
        send_cmd(make_cmd(OP_FIND_PID, 31'd5, 16'd0, JOB_UNDEF));
        send_cmd(make_cmd(OP_REMOVE,   31'd5, 16'd0, JOB_UNDEF));
        send_cmd(make_cmd(OP_FIND_FG,  31'd0, 16'd0, JOB_UNDEF));
        send_cmd(make_cmd(OP_ADD,      31'd0, 16'd1, JOB_FG));
        send_cmd(make_cmd(OP_REMOVE,   31'd0, 16'd0, JOB_UNDEF));
        send_cmd(make_cmd(OP_FIND_PID, 31'd0, 16'd0, JOB_UNDEF));
        send_cmd(make_cmd(OP_SET_PID,  31'd0, 16'd0, JOB_BG));
        send_cmd(make_cmd(OP_FIND_JID, 31'd0, 16'd0, JOB_UNDEF));
        send_cmd(make_cmd(OP_SET_JID,  31'd0, 16'd0, JOB_FG));
        send_cmd(make_cmd(OP_UNUSED,   PID_MAX, JID_MAX, JOB_STOPPED));
        // Max pid added twice: duplicates allowed, lookups take the lowest slot
        send_cmd(make_cmd(OP_ADD,      PID_MAX, 16'd0, JOB_FG));
        send_cmd(make_cmd(OP_ADD,      PID_MAX, 16'd0, JOB_STOPPED));
        send_cmd(make_cmd(OP_ADD,      31'h2aaaaaaa, JID_MAX, JOB_BG));
        send_cmd(make_cmd(OP_FIND_PID, PID_MAX, 16'd0, JOB_UNDEF));
        send_cmd(make_cmd(OP_SET_JID,  31'd0, 16'd2, JOB_FG));
        send_cmd(make_cmd(OP_FIND_FG,  31'd0, 16'd0, JOB_UNDEF));
        send_cmd(make_cmd(OP_SET_PID,  PID_MAX, 16'd0, JOB_UNDEF));
        send_cmd(make_cmd(OP_FIND_FG,  31'd0, 16'd0, JOB_UNDEF));
        send_cmd(make_cmd(OP_FIND_JID, 31'd0, JID_MAX, JOB_UNDEF));
        // Remove the lowest duplicate; the next job id follows the largest left
        send_cmd(make_cmd(OP_REMOVE,   PID_MAX, 16'd0, JOB_UNDEF));
        send_cmd(make_cmd(OP_FIND_JID, 31'd0, 16'd2, JOB_UNDEF));
        send_cmd(make_cmd(OP_ADD,      31'h55555555, 16'd0, JOB_BG));
        send_cmd(make_cmd(OP_SET_PID,  31'h12345, 16'd0, JOB_STOPPED));
        send_cmd(make_cmd(OP_FIND_JID, 31'd0, 16'd4, JOB_UNDEF));
        directed_sent = sent;

        // Random: segments that fill, drain or mix the table. The first segment
        // and one later one run the sender flat out against a long receiver hold.
        counted = 0;
        for (seg = 0; counted < RANDOM_ITEMS; seg++) begin
            seg_bias = (seg == 0) ? BIAS_FILL : $urandom_range(BIAS_FILL, BIAS_MIXED);
            if (seg == 0 || seg == 9) begin
                no_gaps = 1'b1;
                holds_asked++;
            end else begin
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            for (k = 0; k < SEGMENT_LEN; k++) begin
                c = random_cmd(seg_bias);
                send_cmd(c);
                if (c.op != OP_UNUSED) counted++;
            end
        end
        cmd_if.valid <= 1'b0;

        // Drain: let the checker see the last push, then wait for every response
        @(posedge i_clk);
        wait (pending == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d commands (%0d directed), %0d responses checked",
                 sent, directed_sent, checked);
        $display("%0d hits, %0d adds refused on a full table, %0d long receiver holds",
                 hits, full_adds, holds_done);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
